### rtl/ssc_pkg.sv
// Shared types and constants for the stack sequence checker.
// No dependencies; the other files of the block, all but ssc_ram, refer to it by scoped names.
`timescale 1ns / 1ps

package ssc_pkg;

   localparam int FIELD_W = 11;
   // car numbers run one past the largest field value
   localparam int CAR_W = 12;

   localparam logic [FIELD_W-1:0] CFG_RESET = 11'd1024;

   // register index on the configuration port
   localparam logic REG_CAR_COUNT   = 1'b0;
   localparam logic REG_DEPTH_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      RES_POP,
      RES_PUSH,
      RES_FAIL
   } res_kind_type;

   typedef struct packed {
      logic         latch_req;
      logic         pop;
      logic         refill;
      logic         set_fail;
      logic         start_push;
      logic         push_step;
      logic         finish_push;
      logic         load_rsp;
      res_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic failed;
      logic top_hit;
      logic bad;
      logic push_more;
   } dp_sts_type;

endpackage

### rtl/stack_sequence_checker.sv
// Stack sequence checker. A request is latched, then checked; a failure goes
// straight to the result, a pop from the top goes through a stack refill, and
// pushes go through the push loop (one stack RAM write per cycle). A new request
// is taken the cycle after the result is loaded, so only one is in flight.
// Synchronous reset: stack empty, next car 1, failure flag clear, both
// registers 1024; stack RAM contents are left as they are.
`timescale 1ns / 1ps

module stack_sequence_checker #(
   parameter int MAX_CARS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ssc_pkg::FIELD_W-1:0] req_wanted_car,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ssc_pkg::FIELD_W-1:0] rsp_push_count,
   output logic                        rsp_status,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic [ssc_pkg::FIELD_W-1:0] car_count_ff;
   logic [ssc_pkg::FIELD_W-1:0] depth_limit_ff;
   logic                        reg_idx;
   logic                        wr_fire;
   ssc_pkg::dp_cmd_type         cmd;
   ssc_pkg::dp_sts_type         sts;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_fire = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         car_count_ff   <= ssc_pkg::CFG_RESET;
         depth_limit_ff <= ssc_pkg::CFG_RESET;
      end else if (wr_fire) begin
         unique case (reg_idx)
            ssc_pkg::REG_CAR_COUNT:   car_count_ff   <= pwdata[ssc_pkg::FIELD_W-1:0];
            ssc_pkg::REG_DEPTH_LIMIT: depth_limit_ff <= pwdata[ssc_pkg::FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ssc_pkg::REG_CAR_COUNT:   prdata = 32'(car_count_ff);
         ssc_pkg::REG_DEPTH_LIMIT: prdata = 32'(depth_limit_ff);
         default:                  prdata = '0;
      endcase
   end

   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ssc_dpath #(
      .MAX_CARS (MAX_CARS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .car_count      (car_count_ff),
      .depth_limit    (depth_limit_ff),
      .req_wanted_car (req_wanted_car),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_push_count (rsp_push_count),
      .rsp_status     (rsp_status)
   );

endmodule

### rtl/ssc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ssc_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ssc_ctrl.sv
// Sequencer of the stack sequence checker: request intake, check, push loop,
// stack refill and result handoff. Uses ssc_pkg command and status types.
`timescale 1ns / 1ps

module ssc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  ssc_pkg::dp_sts_type sts,
   output ssc_pkg::dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_REFILL,
      S_PUSH,
      S_RESULT
   } state_type;

   state_type             state_ff, state_in;
   ssc_pkg::res_kind_type kind_ff, kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.kind     = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.failed) begin
               kind_in  = ssc_pkg::RES_FAIL;
               state_in = S_RESULT;
            end else if (sts.top_hit) begin
               cmd.pop  = 1'b1;
               kind_in  = ssc_pkg::RES_POP;
               state_in = S_REFILL;
            end else if (sts.bad) begin
               cmd.set_fail = 1'b1;
               kind_in      = ssc_pkg::RES_FAIL;
               state_in     = S_RESULT;
            end else begin
               cmd.start_push = 1'b1;
               kind_in        = ssc_pkg::RES_PUSH;
               state_in       = S_PUSH;
            end
         end
         S_REFILL: begin
            cmd.refill = 1'b1;
            state_in   = S_RESULT;
         end
         S_PUSH: begin
            if (sts.push_more) begin
               cmd.push_step = 1'b1;
            end else begin
               cmd.finish_push = 1'b1;
               state_in        = S_RESULT;
            end
         end
         S_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= ssc_pkg::RES_POP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/ssc_dpath.sv
// Datapath of the stack sequence checker: car counters, stack depth, top of
// stack, the stack RAM (ssc_ram) and the result register. Uses ssc_pkg.
`timescale 1ns / 1ps

module ssc_dpath #(
   parameter int MAX_CARS = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ssc_pkg::FIELD_W-1:0] car_count,
   input  logic [ssc_pkg::FIELD_W-1:0] depth_limit,
   input  logic [ssc_pkg::FIELD_W-1:0] req_wanted_car,
   input  ssc_pkg::dp_cmd_type         cmd,
   output ssc_pkg::dp_sts_type         sts,
   output logic [ssc_pkg::FIELD_W-1:0] rsp_push_count,
   output logic                        rsp_status
);

   localparam int FW = ssc_pkg::FIELD_W;
   localparam int CW = ssc_pkg::CAR_W;
   localparam int DW = $clog2(MAX_CARS + 1);
   localparam int AW = $clog2(MAX_CARS);
   localparam int SW = (DW > CW) ? DW : CW;

   logic [FW-1:0] k_ff;
   logic [CW-1:0] next_car_ff;
   logic [DW-1:0] depth_ff;
   logic [FW-1:0] top_ff;
   logic          failed_ff;
   logic [FW-1:0] pushes_ff;
   logic [FW-1:0] rsp_push_count_ff;
   logic          rsp_status_ff;

   logic [SW-1:0] n_sat;
   logic [SW-1:0] m_sat;
   logic [SW-1:0] k_w;
   logic [SW-1:0] nc_w;
   logic [SW-1:0] need;
   logic [SW:0]   depth_sum;
   logic [DW-1:0] depth_m2;
   logic [FW-1:0] rd_data;

   always_comb begin
      n_sat = (SW'(car_count) > SW'(MAX_CARS)) ? SW'(MAX_CARS) : SW'(car_count);
      m_sat = (SW'(depth_limit) > SW'(MAX_CARS)) ? SW'(MAX_CARS) : SW'(depth_limit);
      k_w   = SW'(k_ff);
      nc_w  = SW'(next_car_ff);
      // only meaningful once the wanted car has not yet entered
      need      = k_w - nc_w + SW'(1);
      depth_sum = {1'b0, SW'(depth_ff)} + {1'b0, need};
      depth_m2  = depth_ff - DW'(2);

      sts.failed    = failed_ff;
      sts.top_hit   = (depth_ff != '0) && (top_ff == k_ff);
      sts.bad       = (k_w < nc_w) || (k_w > n_sat) || (depth_sum > {1'b0, m_sat});
      sts.push_more = (next_car_ff != {1'b0, k_ff});
   end

   ssc_ram #(
      .WIDTH (FW),
      .DEPTH (MAX_CARS)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push_step),
      .wr_addr (depth_ff[AW-1:0]),
      .wr_data (next_car_ff[FW-1:0]),
      .rd_addr (depth_m2[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_car_ff <= CW'(1);
         depth_ff    <= '0;
         failed_ff   <= 1'b0;
      end else begin
         if (cmd.set_fail) begin
            failed_ff <= 1'b1;
         end
         if (cmd.pop) begin
            depth_ff <= depth_ff - DW'(1);
         end else if (cmd.push_step) begin
            depth_ff <= depth_ff + DW'(1);
         end
         if (cmd.push_step) begin
            next_car_ff <= next_car_ff + CW'(1);
         end else if (cmd.finish_push) begin
            next_car_ff <= {1'b0, k_ff} + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         k_ff <= req_wanted_car;
      end
      if (cmd.start_push) begin
         pushes_ff <= need[FW-1:0];
      end
      if (cmd.push_step) begin
         top_ff <= next_car_ff[FW-1:0];
      end else if (cmd.refill) begin
         top_ff <= rd_data;
      end
      if (cmd.load_rsp) begin
         rsp_push_count_ff <= (cmd.kind == ssc_pkg::RES_PUSH) ? pushes_ff : '0;
         rsp_status_ff     <= (cmd.kind == ssc_pkg::RES_FAIL);
      end
   end

   assign rsp_push_count = rsp_push_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

### dv/tb_stack_sequence_checker.sv
// Testbench for stack_sequence_checker: wanted-car requests, register writes, and a
// scoreboard that predicts push count and status per request. Needs rtl/ssc_pkg.sv,
// rtl/stack_sequence_checker.sv, rtl/ssc_ctrl.sv, rtl/ssc_dpath.sv and rtl/ssc_ram.sv.
`timescale 1ns / 1ps

module tb_stack_sequence_checker;

   localparam int MAX_CARS       = 1024;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam int FW             = ssc_pkg::FIELD_W;

   typedef enum {
      FAIL_BURIED,
      FAIL_GONE,
      FAIL_BEYOND,
      FAIL_DEPTH,
      FAIL_NO_CARS
   } fail_kind_type;

   class stack_scoreboard;
      typedef struct packed {
         logic [ssc_pkg::FIELD_W-1:0] push_count;
         logic                        status;
      } outcome_type;

      logic [ssc_pkg::FIELD_W-1:0] car_count_reg   = ssc_pkg::CFG_RESET;
      logic [ssc_pkg::FIELD_W-1:0] depth_limit_reg = ssc_pkg::CFG_RESET;
      int unsigned next_car    = 1;
      int unsigned stack_depth = 0;
      int unsigned stack_cars[MAX_CARS];
      bit          failed      = 1'b0;
      outcome_type outcome_q[$];
      int          errors      = 0;

      function int unsigned cap(logic [ssc_pkg::FIELD_W-1:0] v);
         return (v > MAX_CARS) ? MAX_CARS : v;
      endfunction

      function void set_reg(logic idx, logic [ssc_pkg::FIELD_W-1:0] value);
         if (idx == ssc_pkg::REG_CAR_COUNT) car_count_reg = value;
         else depth_limit_reg = value;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      function int unsigned top_car();
         return stack_cars[stack_depth-1];
      endfunction

      // most extra cars a legal push could stack now, -1 if no push is legal
      function int push_room();
         int a, b;
         a = int'(cap(car_count_reg)) - int'(next_car);
         b = int'(cap(depth_limit_reg)) - int'(stack_depth) - 1;
         if (a < 0 || b < 0) return -1;
         return (a < b) ? a : b;
      endfunction

      function void note_request(logic [ssc_pkg::FIELD_W-1:0] car);
         int unsigned k, pushes;
         outcome_type res;
         k = 32'(car);
         res.push_count = '0;
         res.status = 1'b1;
         if (!failed) begin
            if (stack_depth > 0 && stack_cars[stack_depth-1] == k) begin
               stack_depth--;
               res.status = 1'b0;
            end else if (k < next_car || k > cap(car_count_reg) ||
                         stack_depth + (k - next_car + 1) > cap(depth_limit_reg)) begin
               failed = 1'b1;
            end else begin
               pushes = k - next_car + 1;
               for (int unsigned c = next_car; c < k; c++) begin
                  stack_cars[stack_depth] = c;
                  stack_depth++;
               end
               next_car = k + 1;
               res.push_count = FW'(pushes);
               res.status = 1'b0;
            end
         end
         outcome_q.push_back(res);
      endfunction

      function void check_result(logic [ssc_pkg::FIELD_W-1:0] pc, logic st);
         outcome_type want;
         if (outcome_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, actual push_count %0d status %0d",
                     $time, pc, st);
            return;
         end
         want = outcome_q.pop_front();
         if (pc !== want.push_count) begin
            errors++;
            $display("%0t push_count mismatch: expected %0d, actual %0d",
                     $time, want.push_count, pc);
         end
         if (st !== want.status) begin
            errors++;
            $display("%0t status mismatch: expected %0d, actual %0d", $time, want.status, st);
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [ssc_pkg::FIELD_W-1:0] req_wanted_car = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [ssc_pkg::FIELD_W-1:0] rsp_push_count;
   logic                        rsp_status;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [2:0]                  paddr = '0;
   logic [31:0]                 pwdata = '0;
   logic [31:0]                 prdata;
   logic                        pready;

   stack_scoreboard sb = new();
   int req_count   = 0;
   int rsp_count   = 0;
   int hold_left   = 0;
   bit held        = 1'b0;
   int idle_cycles = 0;

   stack_sequence_checker #(.MAX_CARS(MAX_CARS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_wanted_car(req_wanted_car),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_push_count(rsp_push_count), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // no random idling on either side in this window
   function automatic bit calm();
      return req_count >= 350 && req_count < 550;
   endfunction

   task automatic send_request(input int unsigned car);
      while (!calm() && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_wanted_car <= car[FW-1:0];
      do @(posedge clock); while (req_stall);
      sb.note_request(car[FW-1:0]);
      req_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [ssc_pkg::FIELD_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= ($urandom() & 32'hFFFF_F800) | 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task automatic configure(input logic [ssc_pkg::FIELD_W-1:0] cars,
                            input logic [ssc_pkg::FIELD_W-1:0] depth);
      wait_idle();
      write_reg(ssc_pkg::REG_CAR_COUNT, cars);
      write_reg(ssc_pkg::REG_DEPTH_LIMIT, depth);
   endtask

   // result side: check, then random stall with one long hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_push_count, rsp_status);
            rsp_count++;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!held && rsp_count == 150) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm() && $urandom_range(99) < 26;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[stack_sequence_checker] ERROR");
         $finish;
      end
   end

   initial begin
      fail_kind_type               fail_kind;
      logic [ssc_pkg::FIELD_W-1:0] cars, depth;
      int                          car, room, r, phase_n, run_len;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // pushes and pops under the reset registers
      send_request(1);
      send_request(4);
      send_request(3);
      send_request(2);
      send_request(10);
      send_request(9);
      // wanted car lands exactly on the depth limit
      configure(11'd1024, 11'd6);
      send_request(12);
      send_request(13);
      send_request(11);
      // limit below the current depth: pops only, then single pushes on an empty stack
      configure(11'd1024, 11'd1);
      send_request(8);
      send_request(7);
      configure(11'd1024, 11'd0);
      send_request(6);
      send_request(5);
      configure(11'd1024, 11'd1);
      send_request(14);
      send_request(15);
      // last car equal to n, then saturated registers
      configure(11'd16, 11'd2047);
      send_request(16);
      configure(11'd2047, 11'd2047);
      send_request(20);
      send_request(19);

      // random well-formed sequences, new register setting per phase
      phase_n = 0;
      while (sb.next_car <= 900 && phase_n < 200) begin
         case ($urandom_range(9))
            0:       cars = 11'd0;
            1:       cars = 11'd1;
            2:       cars = 11'd2047;
            3:       cars = FW'($urandom_range(2047, 1025));
            default: cars = 11'd1024;
         endcase
         case ($urandom_range(9))
            0:       depth = 11'd0;
            1:       depth = 11'd1;
            2:       depth = FW'($urandom_range(4, 2));
            3:       depth = 11'd2047;
            4:       depth = FW'($urandom_range(2047, 1025));
            5:       depth = FW'($urandom_range(64, 5));
            default: depth = 11'd1024;
         endcase
         configure(cars, depth);
         run_len = $urandom_range(150, 30);
         for (int i = 0; i < run_len; i++) begin
            room = sb.push_room();
            if (sb.stack_depth > 0 && (room < 0 || $urandom_range(99) < 45)) begin
               car = sb.top_car();
            end else if (room < 0) begin
               break;
            end else begin
               case ($urandom_range(19))
                  0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: r = 0;
                  12, 13, 14, 15: r = $urandom_range(3, 1);
                  16, 17, 18:     r = $urandom_range(16, 4);
                  default:        r = $urandom_range(64, 17);
               endcase
               if (r > room) r = room;
               car = sb.next_car + r;
            end
            send_request(car);
         end
         phase_n++;
      end

      // empty the stack with no cars and no depth allowed
      configure(11'd0, 11'd0);
      while (sb.stack_depth > 0) send_request(sb.top_car());
      configure(11'd2047, 11'd1024);
      // leave two cars stacked, then break the sequence one way
      send_request(sb.next_car + 2);
      fail_kind = fail_kind_type'($urandom_range(4));
      case (fail_kind)
         FAIL_BURIED: send_request(sb.stack_cars[0]);
         FAIL_GONE:   send_request($urandom_range(sb.stack_cars[0] - 1, 1));
         FAIL_BEYOND: send_request($urandom_range(2047, 1025));
         FAIL_DEPTH: begin
            configure(11'd2047, 11'd2);
            send_request(sb.next_car);
         end
         default: begin
            configure(11'd0, 11'd1024);
            send_request(sb.next_car);
         end
      endcase

      // sticky failure: everything after must fail
      for (int i = 0; i < 150; i++) begin
         case ($urandom_range(3))
            0:       send_request($urandom_range(2047, 0));
            1:       send_request($urandom_range(1) ? 2047 : 0);
            2:       send_request(sb.next_car);
            default: send_request(1024);
         endcase
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[stack_sequence_checker] OK");
      end else begin
         $display("[stack_sequence_checker] ERROR");
      end
      $finish;
   end

endmodule
